[hw/rtl/bkdk_pkg.sv]
`timescale 1ns / 1ps

package bkdk_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int KEY_BITS    = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 7;

	typedef struct packed {
		logic [15:0] chain_id;
		logic [31:0] sample_tag;
		logic [31:0] distance;
	} in_beat_t;

	typedef struct packed {
		logic        accepted;
		logic        evicted_valid;
		logic [15:0] evicted_chain;
		logic [31:0] evicted_handle;
		logic [6:0]  kept_count;
		logic [31:0] accepted_total;
		logic [31:0] iteration_total;
		logic [31:0] worst_kept_distance;
	} out_beat_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [15:0]         chain;
		logic [31:0]         handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic      valid;
		out_beat_t beat;
	} done_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVR,
		ST_WALK,
		ST_PUT,
		ST_DONE
	} seq_state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		if (c == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(c) > MAX_ENTRIES) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CNT_W'(c);
		end
	endfunction

endpackage

[hw/rtl/bkdk_ram.sv]
`timescale 1ns / 1ps

module bkdk_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/bkdk_seq.sv]
`timescale 1ns / 1ps

module bkdk_seq
	import bkdk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  in_beat_t         sample,
	input  logic [CNT_W-1:0] cap_eff,
	input  logic             out_free,
	output done_t            done
);

	seq_state_t state_q, state_d;

	entry_t           item_q;
	logic             full_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] top_q;
	logic             acc_q;
	logic             ev_q;
	logic [15:0]      ev_chain_q;
	logic [31:0]      ev_handle_q;
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      acc_tot_q;
	logic [31:0]      iter_tot_q;
	logic [31:0]      worst_q;

	logic             we, re;
	logic [IDX_W-1:0] waddr, raddr;
	entry_t           wdata;
	entry_t           rd;
	logic [ENTRY_W-1:0] rdata;

	logic             accept;
	logic             full_now;
	logic             move;
	logic             fin;

	assign rd       = entry_t'(rdata);
	assign accept   = sample_valid && !sample_stall;
	assign full_now = fill_q >= cap_eff;
	assign move     = full_q ? (rd.key >= item_q.key) : (rd.key > item_q.key);
	assign fin      = (state_q == ST_DONE) && out_free;

	bkdk_ram #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		we           = 1'b0;
		waddr        = idx_q;
		wdata        = item_q;
		re           = 1'b0;
		raddr        = idx_q - IDX_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				raddr        = IDX_W'(fill_q - CNT_W'(1));
				if (sample_valid) begin
					re = (fill_q != '0);
					if (full_now) begin
						state_d = ST_EVR;
					end else if (fill_q == '0) begin
						state_d = ST_PUT;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_EVR: begin
				if (rd.key < item_q.key) begin
					state_d = ST_DONE;
				end else if (idx_q == '0) begin
					state_d = ST_PUT;
				end else begin
					re      = 1'b1;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				we = 1'b1;
				if (move) begin
					wdata = rd;
					if (idx_q == IDX_W'(1)) begin
						state_d = ST_PUT;
					end else begin
						re      = 1'b1;
						raddr   = idx_q - IDX_W'(2);
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PUT: begin
				we      = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.key    <= sample.distance[KEY_BITS-1:0];
			item_q.chain  <= sample.chain_id;
			item_q.handle <= sample.sample_tag;
			full_q        <= full_now;
			acc_q         <= !full_now;
			ev_q          <= 1'b0;
			ev_chain_q    <= '0;
			ev_handle_q   <= '0;
			if (full_now) begin
				idx_q <= IDX_W'(fill_q - CNT_W'(1));
				top_q <= IDX_W'(fill_q - CNT_W'(1));
			end else begin
				idx_q <= IDX_W'(fill_q);
				top_q <= IDX_W'(fill_q);
			end
		end
		if (state_q == ST_EVR && !(rd.key < item_q.key)) begin
			acc_q       <= 1'b1;
			ev_q        <= 1'b1;
			ev_chain_q  <= rd.chain;
			ev_handle_q <= rd.handle;
		end
		if (state_q == ST_WALK && move) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			acc_tot_q  <= '0;
			iter_tot_q <= '0;
			worst_q    <= '0;
		end else begin
			if (we && waddr == top_q) begin
				worst_q <= 32'(wdata.key);
			end
			if (fin) begin
				fill_q     <= done.beat.kept_count[CNT_W-1:0];
				acc_tot_q  <= done.beat.accepted_total;
				iter_tot_q <= done.beat.iteration_total;
			end
		end
	end

	always_comb begin
		done.valid                    = fin;
		done.beat.accepted            = acc_q;
		done.beat.evicted_valid       = ev_q;
		done.beat.evicted_chain       = ev_chain_q;
		done.beat.evicted_handle      = ev_handle_q;
		done.beat.kept_count          = (acc_q && !full_q) ? 7'(fill_q + CNT_W'(1)) : 7'(fill_q);
		done.beat.accepted_total      = acc_q ? sat_inc(acc_tot_q) : acc_tot_q;
		done.beat.iteration_total     = sat_inc(iter_tot_q);
		done.beat.worst_kept_distance = worst_q;
	end

endmodule

[hw/rtl/best_k_distance_keeper.sv]
`timescale 1ns / 1ps
// A sample is taken only while idle: the block finishes one sample and hands its result beat
// to the output register before it takes the next; at most 63 stored entries are shifted.
// One store entry moves per cycle while shifting, through the store's one read port and one
// write port.
// Reset: clears fill, counters and worst distance, sets capacity to 64; the store itself
// is not cleared, only slots below the fill are ever read.
module best_k_distance_keeper
	import bkdk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  in_beat_t         sample,
	output logic             result_valid,
	input  logic             result_stall,
	output out_beat_t        result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_capacity
);

	logic [CAP_W-1:0] cap_q;
	logic             out_free;
	done_t            done;

	assign cfg_ready = 1'b1;
	assign out_free  = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(MAX_ENTRIES);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_capacity;
		end
	end

	bkdk_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.cap_eff     (eff_cap(cap_q)),
		.out_free    (out_free),
		.done        (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (done.valid) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid) begin
			result <= done.beat;
		end
	end

endmodule

[hw/rtl/bkdk_checker.sv]
`timescale 1ns / 1ps

module bkdk_checker
	import bkdk_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input out_beat_t        result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	a_evict_acc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.evicted_valid |-> result.accepted && result.kept_count != '0)
		else $error("eviction without acceptance");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.evicted_valid |->
			result.evicted_chain == '0 && result.evicted_handle == '0)
		else $error("eviction fields not zero");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> int'(result.kept_count) <= MAX_ENTRIES &&
			(result.kept_count != '0 || result.worst_kept_distance == '0))
		else $error("kept count out of range");

	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.iteration_total != '0 &&
			result.accepted_total <= result.iteration_total)
		else $error("totals inconsistent");

endmodule

bind best_k_distance_keeper bkdk_checker u_bkdk_checker (.*);
